>>> src/ubx_frame_parser_pvt_ack_core_assert.svh
// Assertion macros for the UBX frame parser core.
// Taken in by the top level; no other dependencies.
`ifndef UBX_FRAME_PARSER_PVT_ACK_CORE_ASSERT_SVH
`define UBX_FRAME_PARSER_PVT_ACK_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define UFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ufp assertion failed");
// Next-cycle implication, disabled during reset
`define UFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ufp assertion failed");
`else
`define UFP_ASSERT_NOW(label, clk, rst, ante, cons)
`define UFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/ufp_pkg.sv
// Shared types, constants and the PVT field table of the UBX frame parser.
// No dependencies.
package ufp_pkg;

   localparam int UFP_PAYLOAD_BYTES = 128;
   localparam int RSP_TDATA_W       = 88;
   localparam int VALUE_W           = 33;

   localparam logic [7:0]  SYNC_ONE    = 8'hB5;
   localparam logic [7:0]  SYNC_TWO    = 8'h62;
   localparam logic [7:0]  ACK_CLASS   = 8'h05;
   localparam logic [7:0]  ACK_ID      = 8'h01;
   localparam logic [7:0]  NAK_ID      = 8'h00;
   localparam logic [7:0]  NAV_CLASS   = 8'h01;
   localparam logic [7:0]  PVT_ID      = 8'h07;
   localparam logic [15:0] ACK_LEN     = 16'd2;
   localparam logic [15:0] PVT_MIN_LEN = 16'd92;
   localparam logic [7:0]  FIX_MIN     = 8'd2;
   localparam logic [4:0]  VALID_FIELD = 5'd26;

   typedef enum logic [2:0] {
      EV_ACK   = 3'd0,
      EV_NAK   = 3'd1,
      EV_PVT   = 3'd2,
      EV_CKSUM = 3'd3,
      EV_LEN   = 3'd4
   } event_kind_type;

   typedef enum logic [3:0] {
      PH_SYNC1 = 4'd0,
      PH_SYNC2 = 4'd1,
      PH_CLASS = 4'd2,
      PH_ID    = 4'd3,
      PH_LEN_L = 4'd4,
      PH_LEN_H = 4'd5,
      PH_PAY   = 4'd6,
      PH_CKA   = 4'd7,
      PH_CKB   = 4'd8
   } parse_phase_type;

   typedef enum logic [1:0] {
      EM_IDLE,
      EM_READ,
      EM_CAPTURE,
      EM_PUSH
   } emit_state_type;

   // Frame result or error report from the parser to the emitter
   typedef struct packed {
      logic           valid;
      event_kind_type kind;
   } job_type;

   typedef struct packed {
      logic [6:0] offset;
      logic [2:0] nbytes;
      logic       signed_f;
   } field_info_type;

   localparam field_info_type ACK_INFO = '{offset: 7'd0, nbytes: 3'd2, signed_f: 1'b0};

   // Payload offset, byte count and signedness of each PVT field
   function automatic field_info_type ufp_field_info(input logic [4:0] idx);
      field_info_type info;
      unique case (idx)
         5'd0:    info = '{7'd0,  3'd4, 1'b0};
         5'd1:    info = '{7'd4,  3'd2, 1'b0};
         5'd2:    info = '{7'd6,  3'd1, 1'b0};
         5'd3:    info = '{7'd7,  3'd1, 1'b0};
         5'd4:    info = '{7'd8,  3'd1, 1'b0};
         5'd5:    info = '{7'd9,  3'd1, 1'b0};
         5'd6:    info = '{7'd10, 3'd1, 1'b0};
         5'd7:    info = '{7'd11, 3'd1, 1'b0};
         5'd8:    info = '{7'd12, 3'd4, 1'b0};
         5'd9:    info = '{7'd16, 3'd4, 1'b1};
         5'd10:   info = '{7'd20, 3'd1, 1'b0};
         5'd11:   info = '{7'd21, 3'd1, 1'b0};
         5'd12:   info = '{7'd22, 3'd1, 1'b0};
         5'd13:   info = '{7'd23, 3'd1, 1'b0};
         5'd14:   info = '{7'd24, 3'd4, 1'b1};
         5'd15:   info = '{7'd28, 3'd4, 1'b1};
         5'd16:   info = '{7'd32, 3'd4, 1'b1};
         5'd17:   info = '{7'd40, 3'd4, 1'b0};
         5'd18:   info = '{7'd44, 3'd4, 1'b0};
         5'd19:   info = '{7'd48, 3'd4, 1'b1};
         5'd20:   info = '{7'd52, 3'd4, 1'b1};
         5'd21:   info = '{7'd56, 3'd4, 1'b1};
         5'd22:   info = '{7'd60, 3'd4, 1'b1};
         5'd23:   info = '{7'd64, 3'd4, 1'b1};
         5'd24:   info = '{7'd68, 3'd4, 1'b0};
         5'd25:   info = '{7'd72, 3'd4, 1'b0};
         // valid flag is derived from the fix type byte
         5'd26:   info = '{7'd20, 3'd1, 1'b0};
         default: info = '{7'd0,  3'd1, 1'b0};
      endcase
      return info;
   endfunction

endpackage

>>> src/ufp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ufp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ufp_parser.sv
// Byte-level UBX frame parser: sync search, Fletcher-8 checking, payload writes.
// Depends on ufp_pkg; drives the write port of the payload RAM.
module ufp_parser import ufp_pkg::*; #(
   parameter int PAYLOAD_BYTES = UFP_PAYLOAD_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             byte_valid,
   input  logic [7:0]                       byte_data,
   output logic                             wr_en,
   output logic [$clog2(PAYLOAD_BYTES)-1:0] wr_addr,
   output logic [7:0]                       wr_data,
   output job_type                          job,
   output logic [31:0]                      err_count
);

   localparam int AW = $clog2(PAYLOAD_BYTES);
   localparam int IW = $clog2(PAYLOAD_BYTES + 1);

   parse_phase_type phase_ff, phase_in;
   logic [7:0]      class_ff, class_in;
   logic [7:0]      id_ff, id_in;
   logic [15:0]     length_ff, length_in;
   logic [IW-1:0]   index_ff, index_in;
   logic [7:0]      sum_a_ff, sum_a_in;
   logic [7:0]      sum_b_ff, sum_b_in;
   logic [31:0]     err_ff, err_in;
   job_type         job_ff, job_in;

   logic [7:0]    add_a;
   logic [7:0]    add_b;
   logic [15:0]   length_full;
   logic [IW-1:0] index_next;
   logic          len_too_big;
   logic          pay_done;
   logic          cka_ok;
   logic          ckb_ok;
   logic          is_ack;
   logic          is_pvt;

   // Running Fletcher sums and frame checks
   assign add_a       = sum_a_ff + byte_data;
   assign add_b       = sum_b_ff + add_a;
   assign length_full = {byte_data, length_ff[7:0]};
   assign index_next  = index_ff + 1'b1;
   assign len_too_big = length_full > 16'(PAYLOAD_BYTES);
   assign pay_done    = 16'(index_next) >= length_ff;
   assign cka_ok      = byte_data == sum_a_ff;
   assign ckb_ok      = byte_data == sum_b_ff;
   assign is_ack      = (class_ff == ACK_CLASS) && (length_ff == ACK_LEN) &&
                        ((id_ff == ACK_ID) || (id_ff == NAK_ID));
   assign is_pvt      = (class_ff == NAV_CLASS) && (id_ff == PVT_ID) &&
                        (length_ff >= PVT_MIN_LEN);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_SYNC1: phase_in = (byte_data == SYNC_ONE) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2: phase_in = (byte_data == SYNC_TWO) ? PH_CLASS : PH_SYNC1;
            PH_CLASS: phase_in = PH_ID;
            PH_ID:    phase_in = PH_LEN_L;
            PH_LEN_L: phase_in = PH_LEN_H;
            PH_LEN_H: begin
               if (len_too_big) begin
                  phase_in = PH_SYNC1;
               end else if (length_full == 16'd0) begin
                  phase_in = PH_CKA;
               end else begin
                  phase_in = PH_PAY;
               end
            end
            PH_PAY:   phase_in = pay_done ? PH_CKA : PH_PAY;
            PH_CKA:   phase_in = cka_ok ? PH_CKB : PH_SYNC1;
            PH_CKB:   phase_in = PH_SYNC1;
            default:  phase_in = PH_SYNC1;
         endcase
      end
   end

   // Frame fields, sums, error count and report
   always_comb begin
      class_in  = class_ff;
      id_in     = id_ff;
      length_in = length_ff;
      index_in  = index_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      err_in    = err_ff;
      job_in    = '{valid: 1'b0, kind: EV_ACK};
      wr_en     = 1'b0;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_CLASS: begin
               class_in = byte_data;
               sum_a_in = byte_data;
               sum_b_in = byte_data;
            end
            PH_ID: begin
               id_in    = byte_data;
               sum_a_in = add_a;
               sum_b_in = add_b;
            end
            PH_LEN_L: begin
               length_in = {8'd0, byte_data};
               sum_a_in  = add_a;
               sum_b_in  = add_b;
            end
            PH_LEN_H: begin
               length_in = length_full;
               sum_a_in  = add_a;
               sum_b_in  = add_b;
               index_in  = '0;
               if (len_too_big) begin
                  err_in = err_ff + 32'd1;
                  job_in = '{valid: 1'b1, kind: EV_LEN};
               end
            end
            PH_PAY: begin
               wr_en    = 1'b1;
               sum_a_in = add_a;
               sum_b_in = add_b;
               index_in = index_next;
            end
            PH_CKA: begin
               if (!cka_ok) begin
                  err_in = err_ff + 32'd1;
                  job_in = '{valid: 1'b1, kind: EV_CKSUM};
               end
            end
            PH_CKB: begin
               if (!ckb_ok) begin
                  err_in = err_ff + 32'd1;
                  job_in = '{valid: 1'b1, kind: EV_CKSUM};
               end else if (is_ack) begin
                  job_in = '{valid: 1'b1, kind: (id_ff == ACK_ID) ? EV_ACK : EV_NAK};
               end else if (is_pvt) begin
                  job_in = '{valid: 1'b1, kind: EV_PVT};
               end
            end
            default: begin
               sum_a_in = sum_a_ff;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         err_ff   <= '0;
         job_ff   <= '{valid: 1'b0, kind: EV_ACK};
      end else begin
         phase_ff <= phase_in;
         err_ff   <= err_in;
         job_ff   <= job_in;
      end
   end

   // Frame header, index and checksum registers
   always_ff @(posedge clock) begin
      class_ff  <= class_in;
      id_ff     <= id_in;
      length_ff <= length_in;
      index_ff  <= index_in;
      sum_a_ff  <= sum_a_in;
      sum_b_ff  <= sum_b_in;
   end

   assign wr_addr   = index_ff[AW-1:0];
   assign wr_data   = byte_data;
   assign job       = job_ff;
   assign err_count = err_ff;

endmodule

>>> src/ufp_emitter.sv
// Result sequencer: reads the payload RAM byte by byte and builds result transactions.
// Depends on ufp_pkg; drives the read port of the payload RAM and the result register.
module ufp_emitter import ufp_pkg::*; #(
   parameter int PAYLOAD_BYTES = UFP_PAYLOAD_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  job_type                          job,
   input  logic [31:0]                      err_count,
   output logic                             rd_en,
   output logic [$clog2(PAYLOAD_BYTES)-1:0] rd_addr,
   input  logic [7:0]                       rd_data,
   output logic                             byte_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output event_kind_type                   rsp_kind,
   output logic [7:0]                       rsp_class,
   output logic [7:0]                       rsp_id,
   output logic [4:0]                       rsp_index,
   output logic [VALUE_W-1:0]               rsp_value,
   output logic                             rsp_last,
   output logic [31:0]                      rsp_errors
);

   localparam int AW = $clog2(PAYLOAD_BYTES);

   emit_state_type state_ff, state_in;
   event_kind_type kind_ff, kind_in;
   logic [4:0]     fidx_ff, fidx_in;
   logic [1:0]     byte_ff, byte_in;
   logic [31:0]    word_ff, word_in;

   logic               out_valid_ff, out_valid_in;
   event_kind_type     out_kind_ff, out_kind_in;
   logic [7:0]         out_class_ff, out_class_in;
   logic [7:0]         out_id_ff, out_id_in;
   logic [4:0]         out_index_ff, out_index_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic               out_last_ff, out_last_in;
   logic [31:0]        out_errors_ff, out_errors_in;

   field_info_type info;
   logic           is_pvt;
   logic           is_err;
   logic           is_last;
   logic           byte_done;
   logic           push_ok;

   // Field decode and sequencing conditions
   assign is_pvt    = kind_ff == EV_PVT;
   assign is_err    = (kind_ff == EV_CKSUM) || (kind_ff == EV_LEN);
   assign info      = is_pvt ? ufp_field_info(fidx_ff) : ACK_INFO;
   assign is_last   = !is_pvt || (fidx_ff == VALID_FIELD);
   assign byte_done = {1'b0, byte_ff} == (info.nbytes - 3'd1);
   assign push_ok   = (state_ff == EM_PUSH) && (!out_valid_ff || rsp_ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EM_IDLE: begin
            if (job.valid) begin
               state_in = ((job.kind == EV_CKSUM) || (job.kind == EV_LEN)) ? EM_PUSH : EM_READ;
            end
         end
         EM_READ:    state_in = EM_CAPTURE;
         EM_CAPTURE: state_in = byte_done ? EM_PUSH : EM_READ;
         EM_PUSH: begin
            if (push_ok) begin
               state_in = is_last ? EM_IDLE : EM_READ;
            end
         end
         default:    state_in = EM_IDLE;
      endcase
   end

   // Outputs toward the RAM and the parser
   always_comb begin
      rd_en      = state_ff == EM_READ;
      rd_addr    = AW'(info.offset) + AW'(byte_ff);
      byte_ready = (state_ff == EM_IDLE) && !job.valid;
   end

   // Field assembly
   always_comb begin
      kind_in = kind_ff;
      fidx_in = fidx_ff;
      byte_in = byte_ff;
      word_in = word_ff;
      if ((state_ff == EM_IDLE) && job.valid) begin
         kind_in = job.kind;
         fidx_in = '0;
         byte_in = '0;
         word_in = '0;
      end else if (state_ff == EM_CAPTURE) begin
         word_in[{byte_ff, 3'b000} +: 8] = rd_data;
         byte_in = byte_ff + 2'd1;
      end else if (push_ok && !is_last) begin
         fidx_in = fidx_ff + 5'd1;
         byte_in = '0;
         word_in = '0;
      end
   end

   // Result register: load on push, drop once taken
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_class_in  = out_class_ff;
      out_id_in     = out_id_ff;
      out_index_in  = out_index_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      out_errors_in = out_errors_ff;
      if (push_ok) begin
         out_valid_in  = 1'b1;
         out_kind_in   = kind_ff;
         out_class_in  = (is_pvt || is_err) ? 8'd0 : word_ff[7:0];
         out_id_in     = (is_pvt || is_err) ? 8'd0 : word_ff[15:8];
         out_index_in  = is_pvt ? fidx_ff : 5'd0;
         out_last_in   = is_last;
         out_errors_in = err_count;
         if (!is_pvt) begin
            out_value_in = '0;
         end else if (fidx_ff == VALID_FIELD) begin
            out_value_in = VALUE_W'(word_ff[7:0] >= FIX_MIN);
         end else if (info.signed_f) begin
            out_value_in = {word_ff[31], word_ff};
         end else begin
            out_value_in = {1'b0, word_ff};
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EM_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      fidx_ff       <= fidx_in;
      byte_ff       <= byte_in;
      word_ff       <= word_in;
      out_kind_ff   <= out_kind_in;
      out_class_ff  <= out_class_in;
      out_id_ff     <= out_id_in;
      out_index_ff  <= out_index_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
      out_errors_ff <= out_errors_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_class  = out_class_ff;
   assign rsp_id     = out_id_ff;
   assign rsp_index  = out_index_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_errors = out_errors_ff;

endmodule

>>> src/ubx_frame_parser_pvt_ack_core.sv
// UBX frame parser core. One received byte per cycle while no result run is in progress.
// Error result: pushed straight from the report, with no RAM read. ACK/NAK: two RAM reads,
// each a read and a capture state. PVT run: 27 transactions, one RAM read per payload byte
// plus one push per field; input is held off until the last field is pushed.
// Reset (synchronous, active high) clears parser phase, frame report, error count, emitter state
// and result valid; the payload RAM is not cleared, every entry is written before it is read.
module ubx_frame_parser_pvt_ack_core import ufp_pkg::*; #(
   parameter int PAYLOAD_BYTES = UFP_PAYLOAD_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] rx_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [7:0] acked_class, [15:8] acked_id,
                                               // [20:16] field_index, [53:21] field_value,
                                               // [85:54] errors_seen, [87:86] zero
   output logic [2:0]             rsp_tuser,   // [2:0] event_kind
   output logic                   rsp_tlast    // run_last
);

   `include "ubx_frame_parser_pvt_ack_core_assert.svh"

   localparam int AW = $clog2(PAYLOAD_BYTES);

   logic               byte_valid;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [7:0]         wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [7:0]         rd_data;
   job_type            job;
   logic [31:0]        err_count;
   event_kind_type     rsp_kind;
   logic [7:0]         rsp_class;
   logic [7:0]         rsp_id;
   logic [4:0]         rsp_index;
   logic [VALUE_W-1:0] rsp_value;
   logic [31:0]        rsp_errors;

   assign byte_valid = req_tvalid && req_tready;

   ufp_parser #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (req_tdata),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .job        (job),
      .err_count  (err_count)
   );

   ufp_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_BYTES)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ufp_emitter #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_emitter (
      .clock      (clock),
      .reset      (reset),
      .job        (job),
      .err_count  (err_count),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .byte_ready (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_kind   (rsp_kind),
      .rsp_class  (rsp_class),
      .rsp_id     (rsp_id),
      .rsp_index  (rsp_index),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast),
      .rsp_errors (rsp_errors)
   );

   // Pack the result transaction
   assign rsp_tdata = {2'b00, rsp_errors, rsp_value, rsp_index, rsp_id, rsp_class};
   assign rsp_tuser = rsp_kind;

   // Hold off input while a finished frame is handed to the emitter
   `UFP_ASSERT_NOW(a_job_blocks_input, clock, reset, job.valid, !req_tready)
   // A frame report only follows an accepted byte
   `UFP_ASSERT_NEXT(a_job_needs_byte, clock, reset, !byte_valid, !job.valid)
   // Every error report advances the error count by exactly one
   `UFP_ASSERT_NOW(a_err_counted, clock, reset,
      job.valid && ((job.kind == EV_CKSUM) || (job.kind == EV_LEN)),
      err_count == $past(err_count) + 32'd1)

endmodule
